// File: src/der_pk8_pkg.sv
// Package with the types, codes and tag constants shared by the DER key unwrap block.
`default_nettype none
package der_pk8_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH          = 4;

    localparam logic [7:0] TAG_SEQUENCE     = 8'h30;
    localparam logic [7:0] TAG_INTEGER      = 8'h02;
    localparam logic [7:0] TAG_OCTET_STRING = 8'h04;
    localparam logic [7:0] LEN_LONG_FLAG    = 8'h80;
    localparam logic [7:0] LEN_COUNT_MASK   = 8'h7F;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_LEN1    = 3'd1,
        PH_LENX    = 3'd2,
        PH_SKIP    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_TRUNC = 3'd1,
        ST_TAG   = 3'd2,
        ST_FORM  = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic       payload_last;
        t_status    status;
    } t_result;

    // Up to two results per input item, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic [7:0] expected_tag(input logic [1:0] idx);
        logic [7:0] tag;
        unique case (idx)
            2'd0:    tag = TAG_SEQUENCE;
            2'd1:    tag = TAG_INTEGER;
            2'd2:    tag = TAG_SEQUENCE;
            default: tag = TAG_OCTET_STRING;
        endcase
        return tag;
    endfunction

endpackage
`default_nettype wire

// File: src/der_pk8_parse.sv
// Header parser: walks the four tag-length headers and produces payload and status results.
`default_nettype none
module der_pk8_parse #(
    parameter int MAX_LENGTH_BYTES = der_pk8_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire [7:0]            i_data_byte,
    input  wire                  i_final_byte,
    output der_pk8_pkg::t_push   o_push
);
    import der_pk8_pkg::*;

    t_phase      r_phase,   n_phase,   s_phase;
    logic [1:0]  r_hdr,     n_hdr,     s_hdr;
    logic [31:0] r_acc,     n_acc,     s_acc;
    logic [2:0]  r_lbl,     n_lbl,     s_lbl;
    logic [30:0] r_content, n_content, s_content;
    logic [30:0] r_outer,   n_outer,   s_outer;
    t_status     r_err,     n_err,     s_err;

    logic        hd_en;
    logic [31:0] hd_len;
    logic [30:0] content_dec;
    logic [2:0]  lbl_dec;
    logic [31:0] acc_shift;
    logic [6:0]  len_count;

    assign content_dec = (r_content != 31'd0) ? r_content - 31'd1 : 31'd0;
    assign lbl_dec     = (r_lbl != 3'd0) ? r_lbl - 3'd1 : 3'd0;
    assign acc_shift   = {r_acc[23:0], i_data_byte};
    assign len_count   = i_data_byte[6:0] & LEN_COUNT_MASK[6:0];

    // Next state of one byte step, before the end-of-buffer return to reset.
    always_comb begin
        s_phase   = r_phase;
        s_hdr     = r_hdr;
        s_acc     = r_acc;
        s_lbl     = r_lbl;
        s_content = r_content;
        s_err     = r_err;
        s_outer   = (r_hdr != 2'd0 && r_outer != 31'd0) ? r_outer - 31'd1 : r_outer;
        hd_en     = 1'b0;
        hd_len    = 32'd0;

        unique case (r_phase)
            PH_TAG: begin
                if (i_data_byte != expected_tag(r_hdr)) begin
                    s_err   = ST_TAG;
                    s_phase = PH_ERROR;
                end else begin
                    s_phase = PH_LEN1;
                end
            end
            PH_LEN1: begin
                if ((i_data_byte & LEN_LONG_FLAG) == 8'd0) begin
                    hd_en  = 1'b1;
                    hd_len = {24'd0, i_data_byte};
                end else if (len_count == 7'd0 || len_count > 7'(MAX_LENGTH_BYTES)) begin
                    s_err   = ST_FORM;
                    s_phase = PH_ERROR;
                end else begin
                    s_acc   = 32'd0;
                    s_lbl   = len_count[2:0];
                    s_phase = PH_LENX;
                end
            end
            PH_LENX: begin
                s_acc = acc_shift;
                s_lbl = lbl_dec;
                if (lbl_dec == 3'd0) begin
                    hd_en  = 1'b1;
                    hd_len = acc_shift;
                end
            end
            PH_SKIP: begin
                s_content = content_dec;
                if (content_dec == 31'd0) begin
                    s_hdr   = r_hdr + 2'd1;
                    s_phase = PH_TAG;
                end
            end
            PH_PAYLOAD: begin
                s_content = content_dec;
                if (content_dec == 31'd0) begin
                    s_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (hd_en) begin
            if (hd_len[31]) begin
                s_err   = ST_FORM;
                s_phase = PH_ERROR;
            end else if (r_hdr == 2'd0) begin
                s_outer = hd_len[30:0];
                s_hdr   = 2'd1;
                s_phase = PH_TAG;
            end else if (r_hdr != 2'd3) begin
                if (hd_len == 32'd0) begin
                    s_hdr   = r_hdr + 2'd1;
                    s_phase = PH_TAG;
                end else begin
                    s_content = hd_len[30:0];
                    s_phase   = PH_SKIP;
                end
            end else if (hd_len == 32'd0) begin
                s_err   = ST_EMPTY;
                s_phase = PH_ERROR;
            end else begin
                s_content = hd_len[30:0];
                s_phase   = PH_PAYLOAD;
            end
        end
    end

    // The final byte of a buffer returns the parser to its reset state.
    always_comb begin
        if (i_final_byte) begin
            n_phase   = PH_TAG;
            n_hdr     = 2'd0;
            n_acc     = 32'd0;
            n_lbl     = 3'd0;
            n_content = 31'd0;
            n_outer   = 31'd0;
            n_err     = ST_OK;
        end else begin
            n_phase   = s_phase;
            n_hdr     = s_hdr;
            n_acc     = s_acc;
            n_lbl     = s_lbl;
            n_content = s_content;
            n_outer   = s_outer;
            n_err     = s_err;
        end
    end

    // Result items for the accepted byte.
    always_comb begin
        t_result pay;
        t_result stat;
        logic    pay_v;

        pay.kind          = KIND_PAYLOAD;
        pay.payload_byte  = i_data_byte;
        pay.payload_last  = (content_dec == 31'd0);
        pay.status        = ST_OK;
        pay_v             = (r_phase == PH_PAYLOAD);

        stat.kind         = KIND_STATUS;
        stat.payload_byte = 8'd0;
        stat.payload_last = 1'b0;
        if (s_err != ST_OK) begin
            stat.status = s_err;
        end else if (s_phase != PH_DONE || s_outer != 31'd0) begin
            stat.status = ST_TRUNC;
        end else begin
            stat.status = ST_OK;
        end

        o_push.first  = pay_v ? pay : stat;
        o_push.second = stat;
        if (!i_accept) begin
            o_push.count = 2'd0;
        end else begin
            o_push.count = {1'b0, pay_v} + {1'b0, i_final_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TAG;
            r_hdr     <= 2'd0;
            r_acc     <= 32'd0;
            r_lbl     <= 3'd0;
            r_content <= 31'd0;
            r_outer   <= 31'd0;
            r_err     <= ST_OK;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hdr     <= n_hdr;
            r_acc     <= n_acc;
            r_lbl     <= n_lbl;
            r_content <= n_content;
            r_outer   <= n_outer;
            r_err     <= n_err;
        end
    end

endmodule
`default_nettype wire

// File: src/der_pk8_rqueue.sv
// Small queue: up to two result items in per cycle, one out when not stalled.
`default_nettype none
module der_pk8_rqueue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  der_pk8_pkg::t_push   i_push,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output der_pk8_pkg::t_result o_entry,
    output logic                 o_almost_full
);
    import der_pk8_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_result            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic               pop;
    logic [PTR_W-1:0]   wp_next;

    assign pop           = (r_cnt != '0) && !i_out_stall;
    assign wp_next       = r_wp + PTR_W'(1);
    assign o_out_valid   = (r_cnt != '0);
    assign o_entry       = r_mem[r_rp];
    // Room for two more items is needed before the next byte may be taken.
    assign o_almost_full = (r_cnt > CNT_W'(QUEUE_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PTR_W'(i_push.count);
            r_cnt <= r_cnt + CNT_W'(i_push.count) - CNT_W'(pop);
            if (pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: src/der_pk8_key_unwrap_core_top.sv
// Top level of the DER PKCS#8 key unwrap block.
// Order: a result item is written into the result queue at the edge that accepts its byte and is offered in
// queue order; a status that follows a payload byte of the same item is offered after that payload byte.
// Throughput: one byte per cycle; the input stalls while three or more results wait.
// Reset: synchronous, active low; clears the parser state and the result queue pointers.
`default_nettype none
module der_pkcs8_key_unwrap_core #(
    parameter int MAX_LENGTH_BYTES = der_pk8_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire [7:0]  i_data_byte,
    input  wire        i_final_byte,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic       o_result_kind,
    output logic [7:0] o_payload_byte,
    output logic       o_payload_last,
    output logic [2:0] o_status
);
    import der_pk8_pkg::*;

    logic    accept;
    t_push   push;
    t_result entry;

    assign accept = i_in_valid && !o_in_stall;

    der_pk8_parse #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_push       (push)
    );

    der_pk8_rqueue u_rqueue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_entry       (entry),
        .o_almost_full (o_in_stall)
    );

    assign o_result_kind  = entry.kind;
    assign o_payload_byte = entry.payload_byte;
    assign o_payload_last = entry.payload_last;
    assign o_status       = entry.status;

endmodule
`default_nettype wire
